### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: property does not hold");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`endif

### rtl/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// shared constants and types of the integer partition counter
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int MAX_N      = 127;
    localparam int DEPTH      = MAX_N + 1;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int N_W        = 7;
    localparam int CNT_W      = 32;
    localparam int IN_TDATA_W = 8;

    // one read-add-write step: entry a_addr gets entry b_addr added
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
        logic              last;
    } t_step;

    // plain write into the scratch row
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  data;
    } t_wr;

    // final count of one transaction
    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] count;
    } t_done;

endpackage

### rtl/ipc_ram.sv
// ----------------------------------------------------------------------------
// ipc_ram
// generic ram, one write port and two read ports with registered read data
// ----------------------------------------------------------------------------
module ipc_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    // read returns the old contents when the same entry is written
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/ipc_upd.sv
// ----------------------------------------------------------------------------
// ipc_upd
// second half of each step: forward, add and write back into the scratch row
// ----------------------------------------------------------------------------
module ipc_upd (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ipc_pkg::t_step              i_step,
    input  ipc_pkg::t_wr                i_init_wr,
    input  logic [ipc_pkg::CNT_W-1:0]   i_rdata_a,
    input  logic [ipc_pkg::CNT_W-1:0]   i_rdata_b,
    output ipc_pkg::t_wr                o_wr,
    output ipc_pkg::t_done              o_done
);
    import ipc_pkg::*;

    t_step             r_step;
    logic              r_fwd_vld;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [CNT_W-1:0]  r_fwd_data;
    logic [CNT_W-1:0]  op_a;
    logic [CNT_W-1:0]  op_b;
    logic [CNT_W-1:0]  sum;

    // the write of the previous cycle is not yet visible in the read data
    always_comb begin
        op_a = (r_fwd_vld && r_fwd_addr == r_step.a_addr) ? r_fwd_data : i_rdata_a;
        op_b = (r_fwd_vld && r_fwd_addr == r_step.b_addr) ? r_fwd_data : i_rdata_b;
        sum  = op_a + op_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step.vld <= 1'b0;
            r_fwd_vld  <= 1'b0;
        end else begin
            r_step.vld <= i_step.vld;
            r_fwd_vld  <= r_step.vld;
        end
        r_step.a_addr <= i_step.a_addr;
        r_step.b_addr <= i_step.b_addr;
        r_step.last   <= i_step.last;
        r_fwd_addr    <= r_step.a_addr;
        r_fwd_data    <= sum;
    end

    always_comb begin
        if (i_init_wr.we) begin
            o_wr = i_init_wr;
        end else begin
            o_wr.we   = r_step.vld;
            o_wr.addr = r_step.a_addr;
            o_wr.data = sum;
        end
        o_done.vld   = r_step.vld && r_step.last;
        o_done.count = sum;
    end

endmodule

### rtl/ipc_seq.sv
// ----------------------------------------------------------------------------
// ipc_seq
// sequencer: input and output channels, row clear and step issue
// ----------------------------------------------------------------------------
module ipc_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [ipc_pkg::N_W-1:0]       i_n,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [ipc_pkg::CNT_W-1:0]     o_m_axis_tdata,
    output ipc_pkg::t_step                o_step,
    output ipc_pkg::t_wr                  o_init_wr,
    input  ipc_pkg::t_done                i_done
);
    import ipc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RUN,
        ST_WAIT,
        ST_FLUSH
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_n;
    logic [ADDR_W-1:0] r_s;
    logic [ADDR_W-1:0] r_k;
    logic [CNT_W-1:0]  r_res;
    logic              r_ovld;
    logic [CNT_W-1:0]  r_odata;
    logic              in_acc;
    logic              out_load;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load        = (r_state == ST_FLUSH) && (!r_ovld || i_m_axis_tready);

    always_comb begin
        o_step.vld     = (r_state == ST_RUN);
        o_step.a_addr  = r_s;
        o_step.b_addr  = r_s - r_k;
        o_step.last    = (r_k == r_n) && (r_s == r_n);
        o_init_wr.we   = (r_state == ST_INIT);
        o_init_wr.addr = r_s;
        o_init_wr.data = (r_s == '0) ? CNT_W'(1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_n <= i_n[ADDR_W-1:0];
                        r_s <= '0;
                        if (i_n == '0 || i_n > N_W'(MAX_N)) begin
                            r_res   <= '0;
                            r_state <= ST_FLUSH;
                        end else begin
                            r_state <= ST_INIT;
                        end
                    end
                end
                ST_INIT: begin
                    if (r_s == r_n) begin
                        r_k     <= ADDR_W'(1);
                        r_s     <= ADDR_W'(1);
                        r_state <= ST_RUN;
                    end else begin
                        r_s <= r_s + ADDR_W'(1);
                    end
                end
                ST_RUN: begin
                    if (r_s == r_n) begin
                        if (r_k == r_n) begin
                            r_state <= ST_WAIT;
                        end else begin
                            r_k <= r_k + ADDR_W'(1);
                            r_s <= r_k + ADDR_W'(1);
                        end
                    end else begin
                        r_s <= r_s + ADDR_W'(1);
                    end
                end
                ST_WAIT: begin
                    if (i_done.vld) begin
                        r_res   <= i_done.count;
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (out_load) begin
                        r_odata <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;

endmodule

### rtl/integer_partition_counter.sv
// the result transaction follows the input transaction, with the sink ready, after
// the row clear and the read-add-write steps, set by one read-add-write step per
// cycle on the scratch ram; n = 0 skips both
// throughput: one transaction at a time; next input taken once the result is
// in the output register, which may still wait for the sink
// reset: synchronous active-low i_rst_n clears control; scratch ram not cleared
// ----------------------------------------------------------------------------
// integer_partition_counter
// counts the unordered partitions p(n) of n with a one-row scratch table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_partition_counter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream, tdata: [6:0] n, [7] zero fill
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [ipc_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // result stream, tdata: [31:0] partition_count
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [ipc_pkg::CNT_W-1:0]          o_m_axis_tdata
);
    import ipc_pkg::*;

    // scheme: entry 0 is set to 1 and entries 1..n to 0, then for each part
    // size k and each s from k to n, entry s-k is added into entry s. the
    // sequencer issues one step per cycle; the ram returns both operands in the
    // next cycle and the update stage adds and writes back the same cycle.
    // a step for s+1 with k = 1 reads the entry written just before, so the
    // update stage forwards its last write. the final sum is p(n).

    t_step            step;
    t_wr              init_wr;
    t_wr              ram_wr;
    t_done            done;
    logic [CNT_W-1:0] rdata_a;
    logic [CNT_W-1:0] rdata_b;

    // sequencer and io registers
    ipc_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_n             (i_s_axis_tdata[N_W-1:0]),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_step          (step),
        .o_init_wr       (init_wr),
        .i_done          (done)
    );

    // scratch row, one entry per value 0..MAX_N
    ipc_ram #(
        .DATA_W (CNT_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_wr.we),
        .i_waddr   (ram_wr.addr),
        .i_wdata   (ram_wr.data),
        .i_raddr_a (step.a_addr),
        .i_raddr_b (step.b_addr),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // add and write back with one-deep forwarding
    ipc_upd u_upd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_init_wr (init_wr),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_wr      (ram_wr),
        .o_done    (done)
    );

    // row clear and step issue never share a cycle
    `ASSERT_NEVER(a_init_step_excl, i_clk, i_rst_n, init_wr.we && step.vld)

    // the added entry always lies below the updated one
    `ASSERT_HOLDS(a_step_order, i_clk, i_rst_n, step.vld |-> (step.b_addr < step.a_addr))

    // a final count only shows up while a transaction is in progress
    `ASSERT_NEVER(a_done_busy, i_clk, i_rst_n, done.vld && o_s_axis_tready)

    // the last step is followed by its count in the next cycle
    `ASSERT_HOLDS(a_last_done, i_clk, i_rst_n, (step.vld && step.last) |=> done.vld)

endmodule
